[rtl/lic_pkg.sv]
// ----------------------------------------------------------------------------
// Line intersection package
// Control word that travels with each item through the division pipeline.
// ----------------------------------------------------------------------------
package lic_pkg;

    typedef struct packed {
        logic valid;
        logic no_cross;
    } lic_ctl_t;

endpackage

[rtl/lic_div.sv]
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division of unsigned magnitudes, one quotient bit per stage, with
// round half away from zero, saturation to the signed range and a clip flag.
// ----------------------------------------------------------------------------
module lic_div
    import lic_pkg::*;
#(
    parameter int QW = 32,
    parameter int DW = 67
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [DW+QW-1:0]     n_mag,
    input  logic                 n_neg,
    input  logic [DW-1:0]        d_mag,
    input  logic                 d_neg,
    input  lic_ctl_t             ctl_in,
    output logic signed [QW-1:0] quot,
    output logic                 clip,
    output lic_ctl_t             ctl_out
);

    localparam int RW = DW + QW;
    localparam logic [QW:0] LIM_POS = {2'b00, {(QW-1){1'b1}}};
    localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};

    logic [RW-1:0] r_reg    [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [DW-1:0] d_reg    [0:QW];
    logic          neg_reg  [0:QW];
    logic          over_reg [0:QW];
    lic_ctl_t      ctl_reg  [0:QW];

    logic [QW:0]   qr_reg;
    logic          rneg_reg;
    logic          rover_reg;
    lic_ctl_t      rctl_reg;

    logic [QW:0]   qr_next;
    logic          over_next;

    logic signed [QW-1:0] quot_reg;
    logic                 clip_reg;
    lic_ctl_t             octl_reg;

    logic [QW:0]          lim;
    logic                 sat;
    logic [QW:0]          mag;
    logic [QW:0]          sgn;

    // A quotient of 2^QW or more always saturates, so the bit stages only
    // need to produce QW bits.
    assign over_next = n_mag >= {d_mag, {QW{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= n_mag;
            q_reg[0]    <= '0;
            d_reg[0]    <= d_mag;
            neg_reg[0]  <= n_neg ^ d_neg;
            over_reg[0] <= over_next;
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_bit
        localparam int B = QW - s;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(d_reg[s-1]) << B;
        assign ge  = r_reg[s-1] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (en)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s]    <= ge ? (r_reg[s-1] - dsh) : r_reg[s-1];
                q_reg[s]    <= q_reg[s-1] | (ge ? (QW'(1) << B) : '0);
                d_reg[s]    <= d_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                over_reg[s] <= over_reg[s-1];
            end
        end
    end

    assign qr_next = (QW+1)'(q_reg[QW])
                   + (QW+1)'({r_reg[QW], 1'b0} >= (RW+1)'(d_reg[QW]));

    assign lim = rneg_reg ? LIM_NEG : LIM_POS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rctl_reg <= '0;
            octl_reg <= '0;
        end
        else if (en)
        begin
            rctl_reg <= ctl_reg[QW];
            octl_reg <= rctl_reg;
        end
    end

    assign sat = rover_reg || (qr_reg > lim);
    assign mag = sat ? lim : qr_reg;
    assign sgn = rneg_reg ? (~mag + 1'b1) : mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qr_reg    <= qr_next;
            rneg_reg  <= neg_reg[QW];
            rover_reg <= over_reg[QW];
            if (rctl_reg.no_cross)
            begin
                quot_reg <= '0;
                clip_reg <= 1'b0;
            end
            else
            begin
                quot_reg <= $signed(sgn[QW-1:0]);
                clip_reg <= sat;
            end
        end
    end

    assign quot    = quot_reg;
    assign clip    = clip_reg;
    assign ctl_out = octl_reg;

endmodule

[rtl/line_intersection_core.sv]
// ----------------------------------------------------------------------------
// Line intersection core
// Crossing point of two lines, each given by two points, by Cramer's rule.
// ----------------------------------------------------------------------------
// The input channel takes one word per accepted cycle (in_valid high, in_stall
// low): two points of each line, signed fixed point of COORD_BITS bits. The
// output channel gives one word per input word, in order: the crossing point
// in the same format, rounded to nearest with ties away from zero, no_cross
// when the two lines are parallel, coincident or degenerate (coordinates are
// then zero), and clipped when a coordinate saturated.
// Pipeline: five stages of products and sums, then a divider with one range
// check stage, one stage per quotient bit, a rounding stage and a saturation
// stage. Throughput is one word per cycle while the receiver does not stall.
// Reset clears every valid bit; the pipeline comes up empty.
// When the receiver stalls with out_valid high, the whole pipeline holds and
// in_stall is raised in the same cycle; no word is lost or repeated.
// ----------------------------------------------------------------------------
module line_intersection_core
    import lic_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] l1_ax,
    input  logic signed [COORD_BITS-1:0] l1_ay,
    input  logic signed [COORD_BITS-1:0] l1_bx,
    input  logic signed [COORD_BITS-1:0] l1_by,
    input  logic signed [COORD_BITS-1:0] l2_ax,
    input  logic signed [COORD_BITS-1:0] l2_ay,
    input  logic signed [COORD_BITS-1:0] l2_bx,
    input  logic signed [COORD_BITS-1:0] l2_by,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y,
    output logic                         no_cross,
    output logic                         clipped
);

    localparam int W  = COORD_BITS;
    localparam int W1 = W + 1;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int MW = 2 * W + 2;
    localparam int DW = 2 * W + 3;
    localparam int NW = 3 * W + 3;

    logic en;
    logic [5:1] vld_reg;

    logic signed [W1-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0] p11_reg, p12_reg, p21_reg, p22_reg;

    logic signed [W1-1:0] a1s_reg, b1s_reg, a2s_reg, b2s_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [MW-1:0] m1_reg, m2_reg;

    logic signed [DW-1:0] det_reg;
    logic signed [MW-1:0] u1l_reg, u1h_reg, u2l_reg, u2h_reg;
    logic signed [MW-1:0] v1l_reg, v1h_reg, v2l_reg, v2h_reg;

    logic signed [DW-1:0] det4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;

    logic [NW-1:0] nxm_reg, nym_reg;
    logic [DW-1:0] detm_reg;
    logic          nxn_reg, nyn_reg, detn_reg, zero_reg;

    logic signed [W1-1:0] c1l, c1h, c2l, c2h;
    logic signed [DW-1:0] hx_next, lx_next, hy_next, ly_next;
    logic signed [NW-1:0] nx_next, ny_next;

    lic_ctl_t ctl_in;
    lic_ctl_t ctl_x, ctl_y;
    logic     clip_x, clip_y;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    assign c1l = $signed({1'b0, c1_reg[W-1:0]});
    assign c1h = c1_reg[CW-1:W];
    assign c2l = $signed({1'b0, c2_reg[W-1:0]});
    assign c2h = c2_reg[CW-1:W];

    assign hx_next = DW'(u1h_reg) - DW'(u2h_reg);
    assign lx_next = DW'(u1l_reg) - DW'(u2l_reg);
    assign hy_next = DW'(v1h_reg) - DW'(v2h_reg);
    assign ly_next = DW'(v1l_reg) - DW'(v2l_reg);
    assign nx_next = (NW'(hx_next) <<< W) + NW'(lx_next);
    assign ny_next = (NW'(hy_next) <<< W) + NW'(ly_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= W1'(l1_ay) - W1'(l1_by);
            b1_reg  <= W1'(l1_bx) - W1'(l1_ax);
            a2_reg  <= W1'(l2_ay) - W1'(l2_by);
            b2_reg  <= W1'(l2_bx) - W1'(l2_ax);
            p11_reg <= PW'(l1_ax) * PW'(l1_by);
            p12_reg <= PW'(l1_bx) * PW'(l1_ay);
            p21_reg <= PW'(l2_ax) * PW'(l2_by);
            p22_reg <= PW'(l2_bx) * PW'(l2_ay);

            a1s_reg <= a1_reg;
            b1s_reg <= b1_reg;
            a2s_reg <= a2_reg;
            b2s_reg <= b2_reg;
            c1_reg  <= CW'(p11_reg) - CW'(p12_reg);
            c2_reg  <= CW'(p21_reg) - CW'(p22_reg);
            m1_reg  <= MW'(a1_reg) * MW'(b2_reg);
            m2_reg  <= MW'(a2_reg) * MW'(b1_reg);

            det_reg <= DW'(m1_reg) - DW'(m2_reg);
            u1l_reg <= MW'(b1s_reg) * MW'(c2l);
            u1h_reg <= MW'(b1s_reg) * MW'(c2h);
            u2l_reg <= MW'(b2s_reg) * MW'(c1l);
            u2h_reg <= MW'(b2s_reg) * MW'(c1h);
            v1l_reg <= MW'(a2s_reg) * MW'(c1l);
            v1h_reg <= MW'(a2s_reg) * MW'(c1h);
            v2l_reg <= MW'(a1s_reg) * MW'(c2l);
            v2h_reg <= MW'(a1s_reg) * MW'(c2h);

            det4_reg <= det_reg;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;

            nxm_reg  <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            nym_reg  <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            detm_reg <= det4_reg[DW-1] ? DW'(-det4_reg) : DW'(det4_reg);
            nxn_reg  <= nx_reg[NW-1];
            nyn_reg  <= ny_reg[NW-1];
            detn_reg <= det4_reg[DW-1];
            zero_reg <= det4_reg == '0;
        end
    end

    assign ctl_in.valid    = vld_reg[5];
    assign ctl_in.no_cross = zero_reg;

    lic_div #(
        .QW (W),
        .DW (DW)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .n_mag   (nxm_reg),
        .n_neg   (nxn_reg),
        .d_mag   (detm_reg),
        .d_neg   (detn_reg),
        .ctl_in  (ctl_in),
        .quot    (cross_x),
        .clip    (clip_x),
        .ctl_out (ctl_x)
    );

    lic_div #(
        .QW (W),
        .DW (DW)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .n_mag   (nym_reg),
        .n_neg   (nyn_reg),
        .d_mag   (detm_reg),
        .d_neg   (detn_reg),
        .ctl_in  (ctl_in),
        .quot    (cross_y),
        .clip    (clip_y),
        .ctl_out (ctl_y)
    );

    assign out_valid = ctl_x.valid && ctl_y.valid;
    assign no_cross  = ctl_x.no_cross;
    assign clipped   = clip_x || clip_y;

endmodule
